// File: src/assert_macros.svh
// Assertion macros shared by the frame buffer refresh modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lmfr_pkg.sv
// Types and constants of the LED matrix frame buffer refresh block.
package lmfr_pkg;

  localparam logic [2:0] OP_SET_PIXEL  = 3'd0;
  localparam logic [2:0] OP_SET_UPDATE = 3'd1;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
  localparam logic [2:0] OP_UPDATE     = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam int         PIX_PER_MOD = 8;
  localparam logic [7:0] LEFT_BIT    = 8'h80;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] pixel_col;
    logic [3:0] pixel_row;
    logic [2:0] row_index;
    logic [1:0] module_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [7:0] row_byte;
    logic       group_end;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX_WR,
    ST_REFRESH
  } state_t;

  typedef struct packed {
    logic rd_pix;
    logic wr_pix;
    logic wr_byte;
    logic clear;
    logic ref_start;
    logic rd_ref;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       pix_ok;
    logic       wb_ok;
    logic       iss_done;
    logic       ld_last;
    logic       out_free;
  } dp_status_t;

endpackage

// File: src/led_matrix_framebuffer_refresh_top.sv
// Top level of the LED matrix frame buffer and refresh sequencer.
//
//   Channel | Ports                           | Carries
//   input   | in_valid, in_ready, in_data     | one command per transfer
//   result  | out_valid, out_ready, out_data  | one (row address, byte) word per transfer
//
// Write byte, clear and unknown commands complete in the cycle they are taken; set pixel
// reads, then writes, the memory port. An update streams one word per cycle, while
// out_ready is held high, from the single memory read port.
// Reset empties the buffer at once through per-entry valid bits; clear does the same.
// A low out_ready stalls the refresh walk; no command is taken until it ends.
module led_matrix_framebuffer_refresh_top #(
  parameter int ROWS    = 8,
  parameter int MODULES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lmfr_pkg::out_item_t out_data
);
  import lmfr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lmfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lmfr_datapath #(
    .ROWS    (ROWS),
    .MODULES (MODULES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: src/lmfr_datapath.sv
// Frame buffer memory, operand checks and address decode, refresh counters and output register.
`include "assert_macros.svh"

module lmfr_datapath #(
  parameter int ROWS    = 8,
  parameter int MODULES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lmfr_pkg::in_item_t in_data,
  input  lmfr_pkg::dp_cmd_t  cmd,
  output lmfr_pkg::dp_status_t status,
  input  logic               out_ready,
  output logic               out_valid,
  output lmfr_pkg::out_item_t out_data
);
  import lmfr_pkg::*;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MOD_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int ADDR_W = ROW_W + MOD_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int COLS   = MODULES * PIX_PER_MOD;

  logic [7:0]        mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] pix_addr_r;
  logic [7:0]        mask_r;
  logic [ROW_W-1:0]  iss_row_r, ld_row_r;
  logic [MOD_W-1:0]  iss_mod_r, ld_mod_r;
  logic              iss_done_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [7:0]        col_w, row_w, col_m1, row_m1, col_mod, ri_w, mi_w;
  logic              pix_ok, wb_ok, ld_group_end, ld_last, out_free;
  logic [ADDR_W-1:0] pix_addr, wb_addr, raddr, waddr;
  logic [7:0]        pix_mask, wdata;
  logic              mem_we, mem_re;

  assign col_w   = {2'b00, in_data.pixel_col};
  assign row_w   = {4'b0000, in_data.pixel_row};
  assign col_m1  = col_w - 8'd1;
  assign row_m1  = row_w - 8'd1;
  assign col_mod = col_m1 >> 3;
  assign ri_w    = {5'b00000, in_data.row_index};
  assign mi_w    = {6'b000000, in_data.module_index};

  assign pix_ok   = (col_w != 8'd0) && (col_w <= 8'(COLS))
                  && (row_w != 8'd0) && (row_w <= 8'(ROWS));
  assign wb_ok    = (ri_w < 8'(ROWS)) && (mi_w < 8'(MODULES));
  assign pix_addr = {row_m1[ROW_W-1:0], col_mod[MOD_W-1:0]};
  assign pix_mask = LEFT_BIT >> col_m1[2:0];
  assign wb_addr  = {ri_w[ROW_W-1:0], mi_w[MOD_W-1:0]};

  assign mem_re = cmd.rd_pix | cmd.rd_ref;
  assign raddr  = cmd.rd_pix ? pix_addr : {iss_row_r, iss_mod_r};
  assign mem_we = cmd.wr_pix | cmd.wr_byte;
  assign waddr  = cmd.wr_pix ? pix_addr_r : wb_addr;
  assign wdata  = cmd.wr_pix ? (rdata_r | mask_r) : in_data.byte_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= valid_r[raddr] ? mem_r[raddr] : 8'd0;
    end
    if (cmd.rd_pix) begin
      pix_addr_r <= pix_addr;
      mask_r     <= pix_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ref_start) begin
      iss_row_r  <= '0;
      iss_mod_r  <= '0;
      iss_done_r <= 1'b0;
    end else if (cmd.rd_ref) begin
      if (iss_mod_r == MOD_W'(MODULES - 1)) begin
        iss_mod_r <= '0;
        if (iss_row_r == ROW_W'(ROWS - 1)) begin
          iss_done_r <= 1'b1;
        end else begin
          iss_row_r <= iss_row_r + 1'b1;
        end
      end else begin
        iss_mod_r <= iss_mod_r + 1'b1;
      end
    end
  end

  assign ld_group_end = (ld_mod_r == MOD_W'(MODULES - 1));
  assign ld_last      = ld_group_end && (ld_row_r == ROW_W'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ref_start) begin
      ld_row_r <= '0;
      ld_mod_r <= '0;
    end else if (cmd.load_out) begin
      if (ld_group_end) begin
        ld_mod_r <= '0;
        ld_row_r <= ld_last ? '0 : ld_row_r + 1'b1;
      end else begin
        ld_mod_r <= ld_mod_r + 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.row_address <= 4'(ld_row_r) + 4'd1;
      out_data_r.row_byte    <= rdata_r;
      out_data_r.group_end   <= ld_group_end;
      out_data_r.last        <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.opcode   = in_data.opcode;
  assign status.pix_ok   = pix_ok;
  assign status.wb_ok    = wb_ok;
  assign status.iss_done = iss_done_r;
  assign status.ld_last  = ld_last;
  assign status.out_free = out_free;

  `ASSERT_IMP(a_load_into_free, cmd.load_out, !out_valid_r || out_ready, "Output word overwritten before its transfer.")
  `ASSERT_IMP(a_no_read_after_done, cmd.rd_ref, !iss_done_r, "Refresh read issued past the end of the buffer.")

endmodule

// File: src/lmfr_ctrl.sv
// Command sequencer for pixel updates, byte writes, clears and refreshes.
`include "assert_macros.svh"

module lmfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmfr_pkg::dp_status_t status,
  output lmfr_pkg::dp_cmd_t    cmd
);
  import lmfr_pkg::*;

  state_t state_r, state_nxt;
  logic   upd_r, upd_nxt;
  logic   rd_pend_r, rd_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      upd_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      upd_r     <= upd_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    upd_nxt     = upd_r;
    rd_pend_nxt = rd_pend_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (status.opcode) inside
            OP_SET_PIXEL, OP_SET_UPDATE: begin
              if (status.pix_ok) begin
                cmd.rd_pix = 1'b1;
                upd_nxt    = (status.opcode == OP_SET_UPDATE);
                state_nxt  = ST_PIX_WR;
              end
            end
            OP_WRITE_BYTE: cmd.wr_byte = status.wb_ok;
            OP_UPDATE: begin
              cmd.ref_start = 1'b1;
              state_nxt     = ST_REFRESH;
            end
            OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PIX_WR: begin
        cmd.wr_pix = 1'b1;
        if (upd_r) begin
          cmd.ref_start = 1'b1;
          state_nxt     = ST_REFRESH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REFRESH: begin
        cmd.load_out = rd_pend_r && status.out_free;
        cmd.rd_ref   = !status.iss_done && (!rd_pend_r || cmd.load_out);
        if (cmd.rd_ref) begin
          rd_pend_nxt = 1'b1;
        end else if (cmd.load_out) begin
          rd_pend_nxt = 1'b0;
        end
        if (cmd.load_out && status.ld_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_IMP(a_load_needs_data, cmd.load_out, rd_pend_r, "Output loaded without a pending read.")
  `ASSERT_NEXT(a_pix_then_write, cmd.rd_pix, state_r == ST_PIX_WR, "Pixel read not followed by its write.")

endmodule
